// ===== src/gpop_pkg.sv =====
// Shared types and constants for the population update block.
package gpop_pkg;

    localparam int DATA_W  = 32;
    localparam int ACC_W   = 40;
    localparam int IDX_W   = 10;
    localparam int REQ_W   = 2;
    localparam int EPS_W   = 31;
    localparam int COEF_W  = 25;
    localparam int PIU_W   = 11;
    localparam int STAT_W  = 31;
    localparam int DEN_W   = 80;
    localparam int SQ_W    = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [REQ_W-1:0] REQ_NEIGHBOR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STATS    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SQRT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POP_IN_USE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STATS_SCL  = 3'd3;

    localparam logic [EPS_W-1:0]  EPSILON_RST  = 31'd16777;
    localparam logic [COEF_W-1:0] INV_SQRT_RST = 25'd9686330;
    localparam logic [PIU_W-1:0]  POP_USE_RST  = 11'd1024;
    localparam logic [COEF_W-1:0] STATS_SCL_RST = 25'd5215;

    localparam logic [DATA_W-1:0] RECIP_MAX = 32'h7FFF_FFFF;
    localparam logic [STAT_W-1:0] STAT_MAX  = 31'h7FFF_FFFF;

    localparam logic [0:0] RESULT_ENTRY = 1'b0;
    localparam logic [0:0] RESULT_STATS = 1'b1;

    typedef struct packed {
        logic [EPS_W-1:0]  epsilon;
        logic [COEF_W-1:0] inv_sqrt_degree;
        logic [PIU_W-1:0]  population_in_use;
        logic [COEF_W-1:0] stats_scale;
    } gpop_cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_LOAD, ST_NB_READ, ST_NB_MUL, ST_NB_ACC,
        ST_DEN_INIT, ST_DEN, ST_DIV_RE_INIT, ST_DIV_RE, ST_DIV_IM_INIT, ST_DIV_IM,
        ST_UPD_OUT, ST_ST_INIT, ST_ST_RUN, ST_SC_M_LO, ST_SC_M_HI, ST_SC_M_FIN,
        ST_SC_V_LO, ST_SC_V_HI, ST_SC_V_FIN, ST_ST_OUT
    } gpop_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_DECODE, OP_LOAD, OP_NB_READ, OP_NB_MUL, OP_NB_ACC,
        OP_DEN_START, OP_DEN_STEP, OP_DIV_START, OP_DIV_STEP, OP_OUT_UPD,
        OP_ST_START, OP_WALK, OP_SC_LO, OP_SC_HI, OP_SC_FIN, OP_OUT_ST
    } gpop_op_t;

    typedef struct packed {
        gpop_op_t op;
        logic     sel;
    } gpop_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             last;
        logic             den_done;
        logic             den_zero;
        logic             div_done;
        logic             walk_done;
        logic             out_free;
    } gpop_status_t;

endpackage

// ===== src/green_population_update.sv =====
// Top level of the population update block: configuration registers and unit wiring.
//
// Input channel s_*: one request per handshake. req_type selects a neighbour
// term, an entry load or a statistics request; type 3 is dropped.
// Result channel m_*: one result for the final neighbour term of an update and
// one for each statistics request; loads and other terms give none.
// Configuration channel cfg_*: always ready, index selects epsilon,
// inv_sqrt_degree, population_in_use or stats_scale; other indices are dropped.
// A neighbour term is one memory read, one multiply and one accumulate. The
// final term adds a^2+b^2 from 20x20 partial products and the bit-serial
// reciprocal divider (skipped when a^2+b^2 is zero), then the output register.
// A statistics request walks the population one entry a cycle over
// population_in_use entries (clipped to POP_DEPTH).
// Reset clears the open update and the result valid flag and restores the
// configuration defaults; the population memory holds garbage until loaded.
// While a result waits on m_ready the block keeps taking requests and stalls
// only when a new result is ready to be registered.
module green_population_update
    import gpop_pkg::*;
#(
    parameter int POP_DEPTH = 1024,
    parameter int FRAC_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [REQ_W-1:0]         s_req_type,
    input  logic [IDX_W-1:0]         s_target_index,
    input  logic [IDX_W-1:0]         s_neighbor_index,
    input  logic signed [DATA_W-1:0] s_disorder_value,
    input  logic                     s_last_neighbor,
    input  logic signed [DATA_W-1:0] s_entry_real,
    input  logic signed [DATA_W-1:0] s_entry_imag,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_result_kind,
    output logic signed [DATA_W-1:0] m_new_real,
    output logic signed [DATA_W-1:0] m_new_imag,
    output logic [STAT_W-1:0]        m_mean_scaled,
    output logic [STAT_W-1:0]        m_var_scaled,
    output logic                     m_saturated,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    gpop_cfg_t    cfg_reg;
    gpop_cmd_t    cmd;
    gpop_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.epsilon           <= EPSILON_RST;
            cfg_reg.inv_sqrt_degree   <= INV_SQRT_RST;
            cfg_reg.population_in_use <= POP_USE_RST;
            cfg_reg.stats_scale       <= STATS_SCL_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_EPSILON:    cfg_reg.epsilon           <= cfg_data[EPS_W-1:0];
                REG_INV_SQRT:   cfg_reg.inv_sqrt_degree   <= cfg_data[COEF_W-1:0];
                REG_POP_IN_USE: cfg_reg.population_in_use <= cfg_data[PIU_W-1:0];
                REG_STATS_SCL:  cfg_reg.stats_scale       <= cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    gpop_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gpop_dp #(
        .POP_DEPTH (POP_DEPTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg              (cfg_reg),
        .s_req_type       (s_req_type),
        .s_target_index   (s_target_index),
        .s_neighbor_index (s_neighbor_index),
        .s_disorder_value (s_disorder_value),
        .s_last_neighbor  (s_last_neighbor),
        .s_entry_real     (s_entry_real),
        .s_entry_imag     (s_entry_imag),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_new_real       (m_new_real),
        .m_new_imag       (m_new_imag),
        .m_mean_scaled    (m_mean_scaled),
        .m_var_scaled     (m_var_scaled),
        .m_saturated      (m_saturated)
    );

endmodule

// ===== src/gpop_ctrl.sv =====
// Sequencer for the population update block.
module gpop_ctrl
    import gpop_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  gpop_status_t status,
    output gpop_cmd_t    cmd
);

    gpop_state_t state_reg;
    gpop_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                priority if (status.req_type == REQ_NEIGHBOR) state_next = ST_NB_READ;
                else if (status.req_type == REQ_LOAD) state_next = ST_LOAD;
                else if (status.req_type == REQ_STATS) state_next = ST_ST_INIT;
                else state_next = ST_IDLE;
            end
            ST_LOAD:        state_next = ST_IDLE;
            ST_NB_READ:     state_next = ST_NB_MUL;
            ST_NB_MUL:      state_next = ST_NB_ACC;
            ST_NB_ACC:      state_next = status.last ? ST_DEN_INIT : ST_IDLE;
            ST_DEN_INIT:    state_next = ST_DEN;
            ST_DEN: begin
                if (status.den_done) begin
                    state_next = status.den_zero ? ST_UPD_OUT : ST_DIV_RE_INIT;
                end
            end
            ST_DIV_RE_INIT: state_next = ST_DIV_RE;
            ST_DIV_RE: begin
                if (status.div_done) state_next = ST_DIV_IM_INIT;
            end
            ST_DIV_IM_INIT: state_next = ST_DIV_IM;
            ST_DIV_IM: begin
                if (status.div_done) state_next = ST_UPD_OUT;
            end
            ST_UPD_OUT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            ST_ST_INIT:     state_next = ST_ST_RUN;
            ST_ST_RUN: begin
                if (status.walk_done) state_next = ST_SC_M_LO;
            end
            ST_SC_M_LO:     state_next = ST_SC_M_HI;
            ST_SC_M_HI:     state_next = ST_SC_M_FIN;
            ST_SC_M_FIN:    state_next = ST_SC_V_LO;
            ST_SC_V_LO:     state_next = ST_SC_V_HI;
            ST_SC_V_HI:     state_next = ST_SC_V_FIN;
            ST_SC_V_FIN:    state_next = ST_ST_OUT;
            ST_ST_OUT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd.op  = OP_NONE;
        cmd.sel = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = OP_CAPTURE;
            end
            ST_DECODE:      cmd.op = OP_DECODE;
            ST_LOAD:        cmd.op = OP_LOAD;
            ST_NB_READ:     cmd.op = OP_NB_READ;
            ST_NB_MUL:      cmd.op = OP_NB_MUL;
            ST_NB_ACC:      cmd.op = OP_NB_ACC;
            ST_DEN_INIT:    cmd.op = OP_DEN_START;
            ST_DEN: begin
                if (!status.den_done) cmd.op = OP_DEN_STEP;
            end
            ST_DIV_RE_INIT: cmd.op = OP_DIV_START;
            ST_DIV_RE: begin
                if (!status.div_done) cmd.op = OP_DIV_STEP;
            end
            ST_DIV_IM_INIT: begin
                cmd.op  = OP_DIV_START;
                cmd.sel = 1'b1;
            end
            ST_DIV_IM: begin
                if (!status.div_done) cmd.op = OP_DIV_STEP;
            end
            ST_UPD_OUT: begin
                if (status.out_free) cmd.op = OP_OUT_UPD;
            end
            ST_ST_INIT:     cmd.op = OP_ST_START;
            ST_ST_RUN: begin
                if (!status.walk_done) cmd.op = OP_WALK;
            end
            ST_SC_M_LO:     cmd.op = OP_SC_LO;
            ST_SC_M_HI:     cmd.op = OP_SC_HI;
            ST_SC_M_FIN:    cmd.op = OP_SC_FIN;
            ST_SC_V_LO: begin
                cmd.op  = OP_SC_LO;
                cmd.sel = 1'b1;
            end
            ST_SC_V_HI: begin
                cmd.op  = OP_SC_HI;
                cmd.sel = 1'b1;
            end
            ST_SC_V_FIN: begin
                cmd.op  = OP_SC_FIN;
                cmd.sel = 1'b1;
            end
            ST_ST_OUT: begin
                if (status.out_free) cmd.op = OP_OUT_ST;
            end
            default:        cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== src/gpop_dp.sv =====
// Datapath: population memory, accumulator, reciprocal divider, statistics walk, output stage.
module gpop_dp
    import gpop_pkg::*;
#(
    parameter int POP_DEPTH = 1024,
    parameter int FRAC_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  gpop_cmd_t                cmd,
    output gpop_status_t             status,
    input  gpop_cfg_t                cfg,
    input  logic [REQ_W-1:0]         s_req_type,
    input  logic [IDX_W-1:0]         s_target_index,
    input  logic [IDX_W-1:0]         s_neighbor_index,
    input  logic signed [DATA_W-1:0] s_disorder_value,
    input  logic                     s_last_neighbor,
    input  logic signed [DATA_W-1:0] s_entry_real,
    input  logic signed [DATA_W-1:0] s_entry_imag,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_result_kind,
    output logic signed [DATA_W-1:0] m_new_real,
    output logic signed [DATA_W-1:0] m_new_imag,
    output logic [STAT_W-1:0]        m_mean_scaled,
    output logic [STAT_W-1:0]        m_var_scaled,
    output logic                     m_saturated
);

    localparam int AW      = (POP_DEPTH > 1) ? $clog2(POP_DEPTH) : 1;
    localparam int CW0     = $clog2(POP_DEPTH + 1);
    localparam int CNTW    = (CW0 > PIU_W) ? CW0 : PIU_W;
    localparam int MOD_K   = 20;
    localparam int MODW    = IDX_W + 18;
    localparam logic [MOD_K-1:0] MOD_RECIP = MOD_K'((1 << MOD_K) / POP_DEPTH);
    localparam int PROD_W  = DATA_W + COEF_W + 1;
    localparam int NUMW    = ACC_W + 2 * FRAC_BITS;
    localparam int DCW     = $clog2(NUMW + 1);
    localparam int QW      = DATA_W + 1;
    localparam int SUMW    = DATA_W + AW + 1;
    localparam int SCW     = DATA_W + COEF_W;
    localparam int PW      = SQ_W + COEF_W + 1;

    function automatic logic [AW-1:0] wrap_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W+MOD_K-1:0] prod;
        logic [IDX_W-1:0]       q;
        logic [MODW-1:0]        r;
        prod = (IDX_W+MOD_K)'(idx) * (IDX_W+MOD_K)'(MOD_RECIP);
        q    = prod[IDX_W+MOD_K-1:MOD_K];
        r    = MODW'(idx) - MODW'(q) * MODW'(POP_DEPTH);
        if (r >= MODW'(POP_DEPTH)) r = r - MODW'(POP_DEPTH);
        return r[AW-1:0];
    endfunction

    function automatic logic [ACC_W-1:0] mag_acc(input logic signed [ACC_W-1:0] a);
        return a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    endfunction

    // request capture
    logic [REQ_W-1:0]         req_reg;
    logic [IDX_W-1:0]         tgt_reg, nbr_reg;
    logic signed [DATA_W-1:0] dis_reg, ent_re_reg, ent_im_reg;
    logic                     last_reg;
    logic [AW-1:0]            tgt_addr_reg, nbr_addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_CAPTURE) begin
            req_reg    <= s_req_type;
            tgt_reg    <= s_target_index;
            nbr_reg    <= s_neighbor_index;
            dis_reg    <= s_disorder_value;
            last_reg   <= s_last_neighbor;
            ent_re_reg <= s_entry_real;
            ent_im_reg <= s_entry_imag;
        end
        if (cmd.op == OP_DECODE) begin
            tgt_addr_reg <= wrap_idx(tgt_reg);
            nbr_addr_reg <= wrap_idx(nbr_reg);
        end
    end

    // population memory
    logic [DATA_W-1:0] pop_real_mem [POP_DEPTH];
    logic [DATA_W-1:0] pop_imag_mem [POP_DEPTH];
    logic signed [DATA_W-1:0] rd_re_reg, rd_im_reg;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [DATA_W-1:0] wr_re, wr_im;

    logic [CNTW-1:0]   k_reg, n_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pop_real_mem[tgt_addr_reg] <= wr_re;
            pop_imag_mem[tgt_addr_reg] <= wr_im;
        end
        rd_re_reg <= pop_real_mem[rd_addr];
        rd_im_reg <= pop_imag_mem[rd_addr];
    end

    assign rd_addr = (cmd.op == OP_WALK) ? k_reg[AW-1:0] : nbr_addr_reg;

    // accumulator
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic                     open_reg, clipped_reg;
    logic signed [PROD_W-1:0] prod_re_reg, prod_im_reg;
    logic signed [PROD_W-1:0] term_re, term_im;
    logic signed [PROD_W:0]   diff_re, diff_im;
    logic                     ovf_re, ovf_im;
    logic signed [ACC_W-1:0]  acc_re_next, acc_im_next;

    localparam logic [ACC_W-1:0] ACC_MAXV = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MINV = {1'b1, {(ACC_W-1){1'b0}}};

    always_comb begin
        term_re = prod_re_reg >>> FRAC_BITS;
        term_im = prod_im_reg >>> FRAC_BITS;
        diff_re = (PROD_W+1)'(acc_re_reg) - (PROD_W+1)'(term_re);
        diff_im = (PROD_W+1)'(acc_im_reg) - (PROD_W+1)'(term_im);
        ovf_re  = !((&diff_re[PROD_W:ACC_W-1]) || !(|diff_re[PROD_W:ACC_W-1]));
        ovf_im  = !((&diff_im[PROD_W:ACC_W-1]) || !(|diff_im[PROD_W:ACC_W-1]));
        acc_re_next = ovf_re ? (diff_re[PROD_W] ? ACC_MINV : ACC_MAXV) : diff_re[ACC_W-1:0];
        acc_im_next = ovf_im ? (diff_im[PROD_W] ? ACC_MINV : ACC_MAXV) : diff_im[ACC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_re_reg  <= '0;
            acc_im_reg  <= '0;
            open_reg    <= 1'b0;
            clipped_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_NB_READ && !open_reg) begin
                acc_re_reg  <= ACC_W'(dis_reg);
                acc_im_reg  <= ACC_W'(cfg.epsilon);
                clipped_reg <= 1'b0;
                open_reg    <= 1'b1;
            end
            if (cmd.op == OP_NB_ACC) begin
                acc_re_reg  <= acc_re_next;
                acc_im_reg  <= acc_im_next;
                clipped_reg <= clipped_reg | ovf_re | ovf_im;
                if (last_reg) open_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_NB_MUL) begin
            prod_re_reg <= PROD_W'(rd_re_reg) * PROD_W'($signed({1'b0, cfg.inv_sqrt_degree}));
            prod_im_reg <= PROD_W'(rd_im_reg) * PROD_W'($signed({1'b0, cfg.inv_sqrt_degree}));
        end
    end

    // denominator a^2 + b^2 from 20 by 20 bit partial products
    localparam int HW = ACC_W / 2;
    logic [ACC_W-1:0] mag_re, mag_im, den_src;
    logic [3:0]       den_cnt_reg;
    logic [ACC_W-1:0] pp_reg;
    logic [1:0]       pp_sh_reg;
    logic [DEN_W-1:0] den_reg, pp_ext;
    logic [HW-1:0]    x_a, x_b;

    always_comb begin
        mag_re  = mag_acc(acc_re_reg);
        mag_im  = mag_acc(acc_im_reg);
        den_src = den_cnt_reg[2] ? mag_im : mag_re;
        x_a     = den_cnt_reg[1] ? den_src[ACC_W-1:HW] : den_src[HW-1:0];
        x_b     = den_cnt_reg[0] ? den_src[ACC_W-1:HW] : den_src[HW-1:0];
        unique case (pp_sh_reg)
            2'd0:    pp_ext = DEN_W'(pp_reg);
            2'd1:    pp_ext = DEN_W'(pp_reg) << HW;
            default: pp_ext = DEN_W'(pp_reg) << ACC_W;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_DEN_START) begin
            den_cnt_reg <= '0;
            den_reg     <= '0;
        end else if (cmd.op == OP_DEN_STEP) begin
            den_cnt_reg <= den_cnt_reg + 4'd1;
            if (!den_cnt_reg[3]) begin
                pp_reg    <= ACC_W'(x_a) * ACC_W'(x_b);
                pp_sh_reg <= {den_cnt_reg[1] & den_cnt_reg[0], den_cnt_reg[1] ^ den_cnt_reg[0]};
            end
            if (den_cnt_reg != 4'd0) den_reg <= den_reg + pp_ext;
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [NUMW-1:0]  num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W:0]   rem_sh, rem_sub;
    logic             ge;
    logic [QW-1:0]    q_reg, q_lim, q_clip;
    logic             qovf_reg, neg_reg, div_over;
    logic [DCW-1:0]   div_cnt_reg;
    logic [DATA_W-1:0] div_val, res_re_reg;
    logic             res_sat_reg;

    always_comb begin
        rem_sh   = {rem_reg, num_reg[NUMW-1]};
        rem_sub  = rem_sh - {1'b0, den_reg};
        ge       = rem_sh >= {1'b0, den_reg};
        q_lim    = neg_reg ? QW'(33'h0_8000_0000) : QW'(RECIP_MAX);
        div_over = qovf_reg || (q_reg > q_lim);
        q_clip   = div_over ? q_lim : q_reg;
        div_val  = neg_reg ? DATA_W'(-q_clip) : q_clip[DATA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_DIV_START) begin
            num_reg     <= NUMW'(cmd.sel ? mag_im : mag_re) << (2 * FRAC_BITS);
            rem_reg     <= '0;
            q_reg       <= '0;
            qovf_reg    <= 1'b0;
            neg_reg     <= cmd.sel ? (!acc_im_reg[ACC_W-1] && (acc_im_reg != '0))
                                   : acc_re_reg[ACC_W-1];
            div_cnt_reg <= DCW'(NUMW);
            if (cmd.sel) begin
                res_re_reg  <= div_val;
                res_sat_reg <= div_over;
            end
        end else if (cmd.op == OP_DIV_STEP) begin
            rem_reg     <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            num_reg     <= num_reg << 1;
            q_reg       <= {q_reg[QW-2:0], ge};
            qovf_reg    <= qovf_reg | q_reg[QW-1];
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    // statistics walk: read, square, accumulate
    logic signed [SUMW-1:0] im_sum_reg;
    logic [SQ_W-1:0]        sq_sum_reg, sq_prod_reg, sq_sh;
    logic [SQ_W:0]          sq_add;
    logic [DATA_W-1:0]      rd_mag;
    logic                   v1_reg, v2_reg, st_sat_reg;
    logic [CNTW-1:0]        n_next;

    always_comb begin
        n_next = (CNTW'(cfg.population_in_use) > CNTW'(POP_DEPTH))
               ? CNTW'(POP_DEPTH) : CNTW'(cfg.population_in_use);
        rd_mag = rd_im_reg[DATA_W-1] ? DATA_W'(-rd_im_reg) : DATA_W'(rd_im_reg);
        sq_sh  = sq_prod_reg >> FRAC_BITS;
        sq_add = {1'b0, sq_sum_reg} + {1'b0, sq_sh};
    end

    // scaling of both sums
    logic [SQ_W-1:0]   mean_mag, sc_src;
    logic [SCW-1:0]    sc_lo_reg, sc_hi_reg;
    logic [PW-1:0]     sc_full, sc_shift;
    logic              sc_over;
    logic [STAT_W-1:0] sc_val, mean_reg, var_reg;

    always_comb begin
        mean_mag = SQ_W'(im_sum_reg[SUMW-1] ? SUMW'(-im_sum_reg) : SUMW'(im_sum_reg));
        sc_src   = cmd.sel ? sq_sum_reg : mean_mag;
        sc_full  = (PW'(sc_hi_reg) << DATA_W) + PW'(sc_lo_reg);
        sc_shift = sc_full >> FRAC_BITS;
        sc_over  = sc_shift > PW'(STAT_MAX);
        sc_val   = sc_over ? STAT_MAX : sc_shift[STAT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            k_reg  <= '0;
            n_reg  <= '0;
        end else if (cmd.op == OP_ST_START) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            k_reg  <= '0;
            n_reg  <= n_next;
        end else if (cmd.op == OP_WALK) begin
            v1_reg <= k_reg < n_reg;
            v2_reg <= v1_reg;
            if (k_reg < n_reg) k_reg <= k_reg + CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_ST_START) begin
            im_sum_reg <= '0;
            sq_sum_reg <= '0;
            st_sat_reg <= 1'b0;
        end else if (cmd.op == OP_WALK) begin
            if (v1_reg) begin
                im_sum_reg  <= im_sum_reg + SUMW'(rd_im_reg);
                sq_prod_reg <= SQ_W'(rd_mag) * SQ_W'(rd_mag);
            end
            if (v2_reg) begin
                if (sq_add[SQ_W]) begin
                    sq_sum_reg <= '1;
                    st_sat_reg <= 1'b1;
                end else begin
                    sq_sum_reg <= sq_add[SQ_W-1:0];
                end
            end
        end else if (cmd.op == OP_SC_FIN) begin
            st_sat_reg <= st_sat_reg | sc_over;
        end
        if (cmd.op == OP_SC_LO) sc_lo_reg <= SCW'(sc_src[DATA_W-1:0]) * SCW'(cfg.stats_scale);
        if (cmd.op == OP_SC_HI) sc_hi_reg <= SCW'(sc_src[SQ_W-1:DATA_W]) * SCW'(cfg.stats_scale);
        if (cmd.op == OP_SC_FIN) begin
            if (cmd.sel) var_reg  <= sc_val;
            else         mean_reg <= sc_val;
        end
    end

    // memory write and output stage
    logic                     den_zero;
    logic signed [DATA_W-1:0] upd_re, upd_im;
    logic                     upd_sat;
    logic                     m_valid_reg;

    always_comb begin
        den_zero = den_reg == '0;
        upd_re   = den_zero ? RECIP_MAX : res_re_reg;
        upd_im   = den_zero ? '0 : div_val;
        upd_sat  = clipped_reg | den_zero | res_sat_reg | div_over;
        mem_we   = (cmd.op == OP_LOAD) || (cmd.op == OP_OUT_UPD);
        wr_re    = (cmd.op == OP_LOAD) ? ent_re_reg : upd_re;
        wr_im    = (cmd.op == OP_LOAD) ? ent_im_reg : upd_im;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT_UPD || cmd.op == OP_OUT_ST) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUT_UPD) begin
            m_result_kind <= RESULT_ENTRY[0];
            m_new_real    <= upd_re;
            m_new_imag    <= upd_im;
            m_mean_scaled <= '0;
            m_var_scaled  <= '0;
            m_saturated   <= upd_sat;
        end else if (cmd.op == OP_OUT_ST) begin
            m_result_kind <= RESULT_STATS[0];
            m_new_real    <= '0;
            m_new_imag    <= '0;
            m_mean_scaled <= mean_reg;
            m_var_scaled  <= var_reg;
            m_saturated   <= st_sat_reg;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        status.req_type  = req_reg;
        status.last      = last_reg;
        status.den_done  = den_cnt_reg == 4'd9;
        status.den_zero  = den_zero;
        status.div_done  = div_cnt_reg == '0;
        status.walk_done = (k_reg == n_reg) && !v1_reg && !v2_reg;
        status.out_free  = !m_valid_reg || m_ready;
    end

    a_load_keeps_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_LOAD || cmd.op == OP_ST_START) |=> $stable(open_reg))
        else $error("load or statistics changed the open update");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= n_reg)
        else $error("statistics walk passed its length");

    a_no_output_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg)
        else $error("pending result dropped");

endmodule
